// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL; clk and rst are taken from the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SPI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SPI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/spi_pkg.sv =====
// Constants and token types shared by the palette indexer cells and top level.
package spi_pkg;

  localparam int PAL_N  = 64;
  localparam int SPR_N  = 16;
  localparam int PAL_CW = $clog2(PAL_N + 1);
  localparam int SPR_CW = $clog2(SPR_N + 1);
  localparam int PAL_IW = (PAL_N > 1) ? $clog2(PAL_N) : 1;
  localparam int SPR_IW = (SPR_N > 1) ? $clog2(SPR_N) : 1;
  localparam int COLOR_W = 24;
  localparam int IDX_W   = 8;

  // Search word that walks down the palette chain, one cell per cycle.
  typedef struct packed {
    logic               act;
    logic [COLOR_W-1:0] color;
    logic               nsp;
    logic               hit;
    logic               added;
    logic [PAL_CW-1:0]  left;
    logic [PAL_IW-1:0]  pos;
    logic [PAL_IW-1:0]  idx;
  } pal_tok_t;

  // Search word that walks down the sprite chain.
  typedef struct packed {
    logic              act;
    logic [IDX_W-1:0]  key;
    logic              hit;
    logic              added;
    logic [SPR_CW-1:0] left;
    logic [SPR_IW-1:0] pos;
    logic [SPR_IW-1:0] idx;
  } spr_tok_t;

  typedef struct packed {
    logic [IDX_W-1:0] color_index;
    logic             palette_added;
    logic             palette_overflow;
    logic [IDX_W-1:0] sprite_slot;
    logic             sprite_added;
    logic             sprite_overflow;
  } spi_res_t;

endpackage

// ===== rtl/sprite_palette_indexer.sv =====
// One pixel is searched at a time: the search word walks the palette cell chain and then
// the sprite cell chain, one cell per cycle, before the next pixel enters.
// A result that finds the output word stalled parks in a one-word holding register, and no
// pixel is taken until it moves out. Reset clears both counts, so both lists start empty.
module sprite_palette_indexer
  import spi_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       red,
  input  logic [7:0]       green,
  input  logic [7:0]       blue,
  input  logic             new_sprite,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [IDX_W-1:0] color_index,
  output logic             palette_added,
  output logic             palette_overflow,
  output logic [IDX_W-1:0] sprite_slot,
  output logic             sprite_added,
  output logic             sprite_overflow
);

`include "assert_macros.svh"

  pal_tok_t          pal_link [0:PAL_N];
  spr_tok_t          spr_link [0:SPR_N];
  logic [PAL_CW-1:0] pal_count;
  logic [SPR_CW-1:0] spr_count;
  logic              busy;
  logic              p_add;
  logic              p_ovf;
  logic              pend_valid;
  spi_res_t          pend;
  spi_res_t          out_r;
  spi_res_t          res_new;
  logic              accept;
  logic              out_free;
  pal_tok_t          pal_exit;
  spr_tok_t          spr_exit;

  assign accept   = in_valid && in_ready;
  assign in_ready = !busy && !pend_valid;
  assign out_free = !out_valid || out_ready;
  assign pal_exit = pal_link[PAL_N];
  assign spr_exit = spr_link[SPR_N];

  always_comb begin
    pal_link[0]       = '0;
    pal_link[0].act   = accept;
    pal_link[0].color = {red, green, blue};
    pal_link[0].nsp   = new_sprite;
    pal_link[0].left  = pal_count;
  end

  genvar gi;
  generate
    for (gi = 0; gi < PAL_N; gi++) begin : g_pal
      spi_pal_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .tin  (pal_link[gi]),
        .tout (pal_link[gi+1])
      );
    end
  endgenerate

  // A missed color with a full palette goes on as index 0.
  always_comb begin
    spr_link[0]      = '0;
    spr_link[0].act  = pal_exit.act;
    spr_link[0].key  = pal_exit.hit ? IDX_W'(pal_exit.idx) : '0;
    spr_link[0].left = pal_exit.nsp ? '0 : spr_count;
  end

  generate
    for (gi = 0; gi < SPR_N; gi++) begin : g_spr
      spi_spr_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .tin  (spr_link[gi]),
        .tout (spr_link[gi+1])
      );
    end
  endgenerate

  always_comb begin
    res_new.palette_added    = p_add;
    res_new.palette_overflow = p_ovf;
    res_new.sprite_added     = spr_exit.added;
    res_new.sprite_overflow  = !spr_exit.hit;
    res_new.color_index      = spr_exit.hit ? spr_exit.key : '0;
    res_new.sprite_slot      = spr_exit.hit ? IDX_W'(spr_exit.idx) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pal_count  <= '0;
      spr_count  <= '0;
      busy       <= 1'b0;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end
      if (pal_exit.act) begin
        p_add <= pal_exit.added;
        p_ovf <= !pal_exit.hit;
        if (pal_exit.added) begin
          pal_count <= pal_count + PAL_CW'(1);
        end
        if (pal_exit.nsp) begin
          spr_count <= '0;
        end
      end
      if (spr_exit.act) begin
        busy <= 1'b0;
        if (spr_exit.added) begin
          spr_count <= spr_count + SPR_CW'(1);
        end
        if (out_free) begin
          out_r     <= res_new;
          out_valid <= 1'b1;
        end else begin
          pend       <= res_new;
          pend_valid <= 1'b1;
        end
      end else if (out_free) begin
        if (pend_valid) begin
          out_r      <= pend;
          out_valid  <= 1'b1;
          pend_valid <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  assign color_index      = out_r.color_index;
  assign palette_added    = out_r.palette_added;
  assign palette_overflow = out_r.palette_overflow;
  assign sprite_slot      = out_r.sprite_slot;
  assign sprite_added     = out_r.sprite_added;
  assign sprite_overflow  = out_r.sprite_overflow;

  `SPI_ASSERT_IMPL(a_pal_bound, 1'b1, pal_count <= PAL_CW'(PAL_N), "palette count past capacity")
  `SPI_ASSERT_IMPL(a_spr_bound, 1'b1, spr_count <= SPR_CW'(SPR_N), "sprite count past capacity")
  `SPI_ASSERT_IMPL(a_pend_out, pend_valid, out_valid && !busy, "held word without output word")
  `SPI_ASSERT_IMPL(a_flags, out_valid, !(palette_added && palette_overflow) && !(sprite_added && sprite_overflow), "added and overflow together")
  `SPI_ASSERT_NEXT(a_busy, accept, busy && !in_ready, "pixel taken while search in flight")

endmodule

// ===== rtl/spi_pal_cell.sv =====
// One palette cell: holds one color and compares or appends as the search word passes.
module spi_pal_cell
  import spi_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  pal_tok_t tin,
  output pal_tok_t tout
);

  logic [COLOR_W-1:0] entry;
  pal_tok_t           tok_next;
  logic               at_end;
  logic               wr;
  logic               match;

  always_comb begin
    at_end = (tin.left == '0);
    wr     = tin.act && !tin.hit && at_end;
    match  = tin.act && !tin.hit && !at_end && (entry == tin.color);
    tok_next = tin;
    if (wr || match) begin
      tok_next.hit   = 1'b1;
      tok_next.added = wr;
      tok_next.idx   = tin.pos;
    end
    if (!at_end) begin
      tok_next.left = tin.left - PAL_CW'(1);
    end
    tok_next.pos = tin.pos + PAL_IW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tout <= '0;
    end else begin
      tout <= tok_next;
    end
  end

  // The first free cell takes the color when the word arrives unmatched.
  always_ff @(posedge clk) begin
    if (wr) begin
      entry <= tin.color;
    end
  end

endmodule

// ===== rtl/spi_spr_cell.sv =====
// One sprite cell: holds one global index and compares or appends as the search word passes.
module spi_spr_cell
  import spi_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  spr_tok_t tin,
  output spr_tok_t tout
);

  logic [IDX_W-1:0] entry;
  spr_tok_t         tok_next;
  logic             at_end;
  logic             wr;
  logic             match;

  always_comb begin
    at_end = (tin.left == '0);
    wr     = tin.act && !tin.hit && at_end;
    match  = tin.act && !tin.hit && !at_end && (entry == tin.key);
    tok_next = tin;
    if (wr || match) begin
      tok_next.hit   = 1'b1;
      tok_next.added = wr;
      tok_next.idx   = tin.pos;
    end
    if (!at_end) begin
      tok_next.left = tin.left - SPR_CW'(1);
    end
    tok_next.pos = tin.pos + SPR_IW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tout <= '0;
    end else begin
      tout <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      entry <= tin.key;
    end
  end

endmodule
